// File: hdl/ilie_pkg.sv
// ilie_pkg: shared constants, opcodes, status codes and types for the indexed list
// used by every file of the indexed_list_insert_erase block; no dependencies
package ilie_pkg;

  localparam int unsigned DEPTH     = 64;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned POS_W     = 7;
  localparam int unsigned ST_W      = 2;
  localparam int unsigned CNT_OUT_W = 7;
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  // compare width: holds any position, count or cell index plus one spare bit
  localparam int unsigned CMP_W     = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int unsigned GRP_SIZE  = 8;
  localparam int unsigned GRP_N     = (DEPTH + GRP_SIZE - 1) / GRP_SIZE;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_ERASE  = 3'd2,
    OP_READ   = 3'd3,
    OP_WRITE  = 3'd4,
    OP_RESIZE = 3'd5,
    OP_FIRST  = 3'd6,
    OP_LAST   = 3'd7
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_GROUP,
    S_FINAL
  } state_e;

  // command broadcast from the control to every cell
  typedef struct packed {
    logic              load;    // a transaction is accepted this cycle
    logic              apply;   // accepted and passed its checks: the writing ops change the entries
    logic              tap_en;  // the request reads an entry
    op_e               op;
    logic [CMP_W-1:0]  pos;
    logic [CMP_W-1:0]  cnt;
    logic [CMP_W-1:0]  rd_idx;
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

// File: hdl/ilie_if.sv
// ilie_req_if / ilie_rsp_if: valid/ready channels of the indexed list block
// depends on ilie_pkg for field widths
interface ilie_req_if;
  logic                               valid;
  logic                               ready;
  logic [ilie_pkg::OP_W-1:0]          op;
  logic [ilie_pkg::POS_W-1:0]         position;
  logic signed [ilie_pkg::DATA_W-1:0] value;

  modport source (output valid, output op, output position, output value, input ready);
  modport sink   (input valid, input op, input position, input value, output ready);
endinterface

interface ilie_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [ilie_pkg::DATA_W-1:0] read_value;
  logic [ilie_pkg::ST_W-1:0]          status;
  logic [ilie_pkg::CNT_OUT_W-1:0]     count;
  logic                               is_empty;

  modport source (output valid, output read_value, output status, output count,
                  output is_empty, input ready);
  modport sink   (input valid, input read_value, input status, input count,
                  input is_empty, output ready);
endinterface

// File: hdl/ilie_cell.sv
// ilie_cell: one list slot; takes its neighbor's entry on insert or erase
// depends on ilie_pkg for the command struct and opcodes
module ilie_cell (
  input  logic                              clk_i,
  input  logic [ilie_pkg::CMP_W-1:0]        idx_i,
  input  ilie_pkg::cell_cmd_t               cmd_i,
  input  logic [ilie_pkg::DATA_W-1:0]       left_i,
  input  logic [ilie_pkg::DATA_W-1:0]       right_i,
  output logic [ilie_pkg::DATA_W-1:0]       entry_o,
  output logic [ilie_pkg::DATA_W-1:0]       tap_o
);

  localparam int unsigned CW = ilie_pkg::CMP_W;

  logic [ilie_pkg::DATA_W-1:0] entry_d, entry_q;
  logic [ilie_pkg::DATA_W-1:0] tap_d, tap_q;
  logic [CW-1:0]               idx_inc;

  assign idx_inc = idx_i + CW'(1);

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.apply) begin
      unique case (cmd_i.op)
        ilie_pkg::OP_APPEND: begin
          if (idx_i == cmd_i.cnt) entry_d = cmd_i.value;
        end
        ilie_pkg::OP_INSERT: begin
          if (idx_i == cmd_i.pos) begin
            entry_d = cmd_i.value;
          end else if (idx_i > cmd_i.pos && idx_i <= cmd_i.cnt) begin
            entry_d = left_i;
          end
        end
        ilie_pkg::OP_ERASE: begin
          if (idx_i >= cmd_i.pos && idx_inc < cmd_i.cnt) entry_d = right_i;
        end
        ilie_pkg::OP_WRITE: begin
          if (idx_i == cmd_i.pos) entry_d = cmd_i.value;
        end
        ilie_pkg::OP_RESIZE: begin
          // zero fill of the newly exposed slots
          if (idx_i >= cmd_i.cnt && idx_i < cmd_i.pos) entry_d = '0;
        end
        default: begin
          entry_d = entry_q;
        end
      endcase
    end
  end

  assign tap_d = (cmd_i.tap_en && idx_i == cmd_i.rd_idx) ? entry_q : '0;

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    if (cmd_i.load) tap_q <= tap_d;
  end

  assign entry_o = entry_q;
  assign tap_o   = tap_q;

endmodule

// File: hdl/indexed_list_insert_erase.sv
// indexed_list_insert_erase: top level, control, cell row and read gather tree
// depends on ilie_pkg, ilie_if (ilie_req_if, ilie_rsp_if) and ilie_cell
//
//   channel  | dir | handshake     | payload
//   req_i    | in  | valid / ready | op, position, value
//   rsp_o    | out | valid / ready | read_value, status, count, is_empty
//
// each request flows through the cell row, which updates and taps the read entry
// at accept; groups of 8 taps are or-ed into registers, then the groups are or-ed
// into the output register. the control takes no new request until the previous
// result is loaded into the output register, but takes one while that result still
// waits there; the final stage waits when that register is still full.
// rst_ni clears the count, the control and the output valid; entries keep no reset.
module indexed_list_insert_erase (
  input  logic          clk_i,
  input  logic          rst_ni,
  ilie_req_if.sink      req_i,
  ilie_rsp_if.source    rsp_o
);

  localparam int unsigned CW = ilie_pkg::CMP_W;
  localparam int unsigned DW = ilie_pkg::DATA_W;

  ilie_pkg::state_e   state_d, state_q;
  logic [ilie_pkg::CNT_W-1:0] count_d, count_q;
  ilie_pkg::status_e  st_d, st_q;
  ilie_pkg::cell_cmd_t cmd;
  ilie_pkg::op_e      op;

  logic               acc;
  logic               in_ready;
  logic               grp_en;
  logic               out_load;

  logic [CW-1:0]      n;
  logic [CW-1:0]      p;
  logic [CW-1:0]      depth_c;
  logic               ok;

  logic [DW-1:0]      entry [ilie_pkg::DEPTH];
  logic [DW-1:0]      tap   [ilie_pkg::DEPTH];
  logic [DW-1:0]      grp_d [ilie_pkg::GRP_N];
  logic [DW-1:0]      grp_q [ilie_pkg::GRP_N];
  logic [DW-1:0]      rd_sum;

  logic               out_valid_d, out_valid_q;
  logic [DW-1:0]      out_rd_q;
  ilie_pkg::status_e  out_st_q;
  logic [CW-1:0]      out_cnt_q;

  // request decode against the current count
  assign op      = ilie_pkg::op_e'(req_i.op);
  assign n       = CW'(count_q);
  assign p       = CW'(req_i.position);
  assign depth_c = CW'(ilie_pkg::DEPTH);
  assign acc     = req_i.valid && in_ready;

  always_comb begin
    st_d = ilie_pkg::ST_OK;
    unique case (op)
      ilie_pkg::OP_APPEND: if (n >= depth_c) st_d = ilie_pkg::ST_FULL;
      ilie_pkg::OP_INSERT: begin
        if (p > n) begin
          st_d = ilie_pkg::ST_RANGE;
        end else if (n >= depth_c) begin
          st_d = ilie_pkg::ST_FULL;
        end
      end
      ilie_pkg::OP_ERASE,
      ilie_pkg::OP_READ,
      ilie_pkg::OP_WRITE:  if (p >= n) st_d = ilie_pkg::ST_RANGE;
      ilie_pkg::OP_RESIZE: if (p > depth_c) st_d = ilie_pkg::ST_FULL;
      ilie_pkg::OP_FIRST,
      ilie_pkg::OP_LAST:   if (n == '0) st_d = ilie_pkg::ST_RANGE;
      default:             st_d = ilie_pkg::ST_OK;
    endcase
  end

  assign ok = (st_d == ilie_pkg::ST_OK);

  always_comb begin
    count_d = count_q;
    if (acc && ok) begin
      unique case (op)
        ilie_pkg::OP_APPEND,
        ilie_pkg::OP_INSERT: count_d = count_q + ilie_pkg::CNT_W'(1);
        ilie_pkg::OP_ERASE:  count_d = count_q - ilie_pkg::CNT_W'(1);
        ilie_pkg::OP_RESIZE: count_d = ilie_pkg::CNT_W'(p);
        default:             count_d = count_q;
      endcase
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.load   = acc;
    cmd.apply  = acc && ok;
    cmd.op     = op;
    cmd.pos    = p;
    cmd.cnt    = n;
    cmd.value  = req_i.value;
    cmd.tap_en = ok && (op == ilie_pkg::OP_READ || op == ilie_pkg::OP_FIRST ||
                        op == ilie_pkg::OP_LAST);
    unique case (op)
      ilie_pkg::OP_FIRST: cmd.rd_idx = '0;
      ilie_pkg::OP_LAST:  cmd.rd_idx = n - CW'(1);
      default:            cmd.rd_idx = p;
    endcase
  end

  // row of cells, each handing its entry to both neighbors
  for (genvar i = 0; i < ilie_pkg::DEPTH; i++) begin : g_cell
    logic [DW-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = entry[i-1];
    end
    if (i == ilie_pkg::DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = entry[i+1];
    end
    ilie_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (CW'(i)),
      .cmd_i   (cmd),
      .left_i  (left_w),
      .right_i (right_w),
      .entry_o (entry[i]),
      .tap_o   (tap[i])
    );
  end

  // read gather: first level or over groups of taps
  always_comb begin
    for (int g = 0; g < int'(ilie_pkg::GRP_N); g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < int'(ilie_pkg::GRP_SIZE); k++) begin
        if (g * int'(ilie_pkg::GRP_SIZE) + k < int'(ilie_pkg::DEPTH)) begin
          grp_d[g] = grp_d[g] | tap[g * int'(ilie_pkg::GRP_SIZE) + k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (grp_en) begin
      for (int g = 0; g < int'(ilie_pkg::GRP_N); g++) grp_q[g] <= grp_d[g];
    end
  end

  always_comb begin
    rd_sum = '0;
    for (int g = 0; g < int'(ilie_pkg::GRP_N); g++) rd_sum = rd_sum | grp_q[g];
  end

  // control: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ilie_pkg::S_IDLE:  if (req_i.valid) state_d = ilie_pkg::S_GROUP;
      ilie_pkg::S_GROUP: state_d = ilie_pkg::S_FINAL;
      ilie_pkg::S_FINAL: if (!out_valid_q || rsp_o.ready) state_d = ilie_pkg::S_IDLE;
      default:           state_d = ilie_pkg::S_IDLE;
    endcase
  end

  // control: outputs
  always_comb begin
    in_ready = 1'b0;
    grp_en   = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      ilie_pkg::S_IDLE:  in_ready = 1'b1;
      ilie_pkg::S_GROUP: grp_en   = 1'b1;
      ilie_pkg::S_FINAL: out_load = !out_valid_q || rsp_o.ready;
      default:           in_ready = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ilie_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) st_q <= st_d;
    if (out_load) begin
      out_rd_q  <= rd_sum;
      out_st_q  <= st_q;
      out_cnt_q <= n;
    end
  end

  assign req_i.ready      = in_ready;
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.read_value = out_rd_q;
  assign rsp_o.status     = out_st_q;
  assign rsp_o.count      = out_cnt_q[ilie_pkg::CNT_OUT_W-1:0];
  assign rsp_o.is_empty   = (out_cnt_q == '0);

  // the count never runs past the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n <= depth_c)
    else $error("count above capacity");

  // an accepted transaction moves on to the gather stage
  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> state_q == ilie_pkg::S_GROUP)
    else $error("accept not followed by gather");

  // loading the output register raises valid
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q)
    else $error("output load lost");

  // an append to a full list leaves the count alone
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && op == ilie_pkg::OP_APPEND && n == depth_c |=> n == depth_c)
    else $error("full append changed the count");

endmodule

// File: verif/tb_indexed_list_insert_erase.sv
// tb_indexed_list_insert_erase: self-checking bench for the indexed list block
// depends on ilie_pkg, ilie_req_if / ilie_rsp_if and indexed_list_insert_erase
// a directed table then random requests, scored against a local list predictor or the table's expected result
`timescale 1ns / 1ps

module tb_indexed_list_insert_erase;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_ITEMS = 1500;
  localparam int MAX_WAIT     = 11;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic signed [ilie_pkg::DATA_W-1:0] read_value;
    ilie_pkg::status_e                  status;
    logic [ilie_pkg::CNT_OUT_W-1:0]     count;
    logic                               is_empty;
  } list_rsp_t;

  typedef struct {
    ilie_pkg::op_e                      op;
    logic [ilie_pkg::POS_W-1:0]         pos;
    logic signed [ilie_pkg::DATA_W-1:0] value;
    bit                                 typed;
    list_rsp_t                          rsp;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  ilie_req_if req_if ();
  ilie_rsp_if rsp_if ();

  indexed_list_insert_erase u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // shadow copy of the list, advanced at every accepted request
  logic signed [ilie_pkg::DATA_W-1:0] shadow_cells [ilie_pkg::DEPTH];
  int                                 shadow_len;

  list_rsp_t pending_rsp [$];
  stim_row_t dir_rows [$];
  int        err_cnt = 0;
  int        sent_cnt;
  int        rcvd_cnt;
  int        cycles = 0;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_indexed_list_insert_erase: done, errors");
      $finish;
    end
  end

  function automatic list_rsp_t predict_list(input ilie_pkg::op_e op,
                                             input logic [ilie_pkg::POS_W-1:0] pos,
                                             input logic signed [ilie_pkg::DATA_W-1:0] val);
    list_rsp_t r;
    int        n;
    int        p;
    int        i;
    r.read_value = '0;
    r.status     = ilie_pkg::ST_OK;
    n = shadow_len;
    p = int'(pos);
    case (op)
      ilie_pkg::OP_APPEND: begin
        if (n >= ilie_pkg::DEPTH) r.status = ilie_pkg::ST_FULL;
        else begin
          shadow_cells[n] = val;
          shadow_len = n + 1;
        end
      end
      ilie_pkg::OP_INSERT: begin
        // range is checked before fullness
        if (p > n) r.status = ilie_pkg::ST_RANGE;
        else if (n >= ilie_pkg::DEPTH) r.status = ilie_pkg::ST_FULL;
        else begin
          for (i = n; i > p; i--) shadow_cells[i] = shadow_cells[i-1];
          shadow_cells[p] = val;
          shadow_len = n + 1;
        end
      end
      ilie_pkg::OP_ERASE: begin
        if (p >= n) r.status = ilie_pkg::ST_RANGE;
        else begin
          for (i = p; i + 1 < n; i++) shadow_cells[i] = shadow_cells[i+1];
          shadow_len = n - 1;
        end
      end
      ilie_pkg::OP_READ: begin
        if (p >= n) r.status = ilie_pkg::ST_RANGE;
        else r.read_value = shadow_cells[p];
      end
      ilie_pkg::OP_WRITE: begin
        if (p >= n) r.status = ilie_pkg::ST_RANGE;
        else shadow_cells[p] = val;
      end
      ilie_pkg::OP_RESIZE: begin
        if (p > ilie_pkg::DEPTH) r.status = ilie_pkg::ST_FULL;
        else begin
          for (i = n; i < p; i++) shadow_cells[i] = '0;
          shadow_len = p;
        end
      end
      ilie_pkg::OP_FIRST: begin
        if (n == 0) r.status = ilie_pkg::ST_RANGE;
        else r.read_value = shadow_cells[0];
      end
      default: begin
        if (n == 0) r.status = ilie_pkg::ST_RANGE;
        else r.read_value = shadow_cells[n-1];
      end
    endcase
    r.count    = ilie_pkg::CNT_OUT_W'(shadow_len);
    r.is_empty = (shadow_len == 0);
    return r;
  endfunction

  task automatic add_row(input ilie_pkg::op_e op, input int pos,
                         input logic signed [ilie_pkg::DATA_W-1:0] val,
                         input bit typed, input logic signed [ilie_pkg::DATA_W-1:0] rv,
                         input ilie_pkg::status_e st, input int cnt, input bit emp);
    stim_row_t row;
    row.op             = op;
    row.pos            = ilie_pkg::POS_W'(pos);
    row.value          = val;
    row.typed          = typed;
    row.rsp.read_value = rv;
    row.rsp.status     = st;
    row.rsp.count      = ilie_pkg::CNT_OUT_W'(cnt);
    row.rsp.is_empty   = emp;
    dir_rows = {dir_rows, row};
  endtask

  task automatic send_req(input stim_row_t row);
    int        gap;
    list_rsp_t want;
    // every 200 requests a stretch of 50 goes back to back
    gap = (sent_cnt % 200 >= 150) ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.op       <= row.op;
    req_if.position <= row.pos;
    req_if.value    <= row.value;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    want = predict_list(row.op, row.pos, row.value);
    if (row.typed) want = row.rsp;
    pending_rsp = {pending_rsp, want};
    sent_cnt++;
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    stim_row_t row;
    int        k;
    int        pick;
    int        n;
    req_if.valid    = 1'b0;
    req_if.op       = ilie_pkg::OP_APPEND;
    req_if.position = '0;
    req_if.value    = '0;
    rst_ni          = 1'b0;
    sent_cnt        = 0;
    shadow_len      = 0;
    for (k = 0; k < ilie_pkg::DEPTH; k++) shadow_cells[k] = '0;

    // empty list: every read and position error
    add_row(ilie_pkg::OP_FIRST,   0, 0, 1, 0, ilie_pkg::ST_RANGE, 0, 1);
    add_row(ilie_pkg::OP_LAST,    0, 0, 1, 0, ilie_pkg::ST_RANGE, 0, 1);
    add_row(ilie_pkg::OP_READ,    0, 0, 1, 0, ilie_pkg::ST_RANGE, 0, 1);
    add_row(ilie_pkg::OP_ERASE,   0, 0, 1, 0, ilie_pkg::ST_RANGE, 0, 1);
    add_row(ilie_pkg::OP_WRITE,   0, 0, 1, 0, ilie_pkg::ST_RANGE, 0, 1);
    add_row(ilie_pkg::OP_INSERT,  1, 0, 1, 0, ilie_pkg::ST_RANGE, 0, 1);
    // value extremes
    add_row(ilie_pkg::OP_APPEND,  0, 64'sh7FFF_FFFF_FFFF_FFFF, 1, 0, ilie_pkg::ST_OK, 1, 0);
    add_row(ilie_pkg::OP_INSERT,  0, 64'sh8000_0000_0000_0000, 1, 0, ilie_pkg::ST_OK, 2, 0);
    add_row(ilie_pkg::OP_FIRST,   0, 0, 1, 64'sh8000_0000_0000_0000, ilie_pkg::ST_OK, 2, 0);
    add_row(ilie_pkg::OP_LAST,    0, 0, 1, 64'sh7FFF_FFFF_FFFF_FFFF, ilie_pkg::ST_OK, 2, 0);
    add_row(ilie_pkg::OP_WRITE,   1, -64'sd1, 1, 0, ilie_pkg::ST_OK, 2, 0);
    add_row(ilie_pkg::OP_READ,    1, 0, 1, -64'sd1, ilie_pkg::ST_OK, 2, 0);
    add_row(ilie_pkg::OP_ERASE,   0, 0, 0, 0, ilie_pkg::ST_OK, 0, 0);
    // grow to full with zero fill, then the full and range cases
    add_row(ilie_pkg::OP_RESIZE, 64, 0, 1, 0, ilie_pkg::ST_OK, 64, 0);
    add_row(ilie_pkg::OP_APPEND,  0, 64'sh0123_4567_89AB_CDEF, 1, 0, ilie_pkg::ST_FULL, 64, 0);
    add_row(ilie_pkg::OP_INSERT, 64, 64'sh0F0F_0F0F_0F0F_0F0F, 1, 0, ilie_pkg::ST_FULL, 64, 0);
    add_row(ilie_pkg::OP_INSERT, 65, 0, 1, 0, ilie_pkg::ST_RANGE, 64, 0);
    add_row(ilie_pkg::OP_READ,   63, 0, 1, 0, ilie_pkg::ST_OK, 64, 0);
    add_row(ilie_pkg::OP_READ,   64, 0, 1, 0, ilie_pkg::ST_RANGE, 64, 0);
    add_row(ilie_pkg::OP_RESIZE, 65, 0, 1, 0, ilie_pkg::ST_FULL, 64, 0);
    add_row(ilie_pkg::OP_RESIZE, 127, 0, 1, 0, ilie_pkg::ST_FULL, 64, 0);
    // shrink to nothing, regrow reads back zeros
    add_row(ilie_pkg::OP_RESIZE,  0, 0, 1, 0, ilie_pkg::ST_OK, 0, 1);
    add_row(ilie_pkg::OP_RESIZE,  2, 0, 0, 0, ilie_pkg::ST_OK, 0, 0);
    add_row(ilie_pkg::OP_READ,    0, 0, 1, 0, ilie_pkg::ST_OK, 2, 0);
    add_row(ilie_pkg::OP_ERASE,   1, 0, 0, 0, ilie_pkg::ST_OK, 0, 0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_req(dir_rows[i]);
    wait_drained();

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      n         = shadow_len;
      row.typed = 1'b0;
      row.rsp   = '0;
      pick      = $urandom_range(0, 99);
      if (pick < 18)      row.op = ilie_pkg::OP_APPEND;
      else if (pick < 34) row.op = ilie_pkg::OP_INSERT;
      else if (pick < 52) row.op = ilie_pkg::OP_ERASE;
      else if (pick < 64) row.op = ilie_pkg::OP_READ;
      else if (pick < 74) row.op = ilie_pkg::OP_WRITE;
      else if (pick < 80) row.op = ilie_pkg::OP_RESIZE;
      else if (pick < 90) row.op = ilie_pkg::OP_FIRST;
      else                row.op = ilie_pkg::OP_LAST;

      // mostly legal positions for the current length, some anywhere
      if ($urandom_range(0, 99) < 15) begin
        row.pos = ilie_pkg::POS_W'($urandom_range(0, 127));
      end else if (row.op == ilie_pkg::OP_RESIZE) begin
        row.pos = ilie_pkg::POS_W'($urandom_range(0, ilie_pkg::DEPTH));
      end else if (row.op == ilie_pkg::OP_INSERT) begin
        row.pos = ilie_pkg::POS_W'($urandom_range(0, n));
      end else begin
        row.pos = ilie_pkg::POS_W'((n == 0) ? 0 : $urandom_range(0, n - 1));
      end

      pick = $urandom_range(0, 19);
      case (pick)
        0:       row.value = 64'sh7FFF_FFFF_FFFF_FFFF;
        1:       row.value = 64'sh8000_0000_0000_0000;
        2:       row.value = -64'sd1;
        3:       row.value = '0;
        default: row.value = {$urandom, $urandom};
      endcase

      send_req(row);
      if (k % 300 == 299) wait_drained();
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0 && pending_rsp.size() == 0) begin
      $display("tb_indexed_list_insert_erase: done, clean");
    end else begin
      $display("tb_indexed_list_insert_erase: done, errors");
    end
    $finish;
  end

  initial begin : result_sink
    int        stall;
    list_rsp_t got;
    list_rsp_t want;
    rsp_if.ready = 1'b0;
    rcvd_cnt     = 0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      // a stretch of 40 results every 250 takes no stalls
      stall = (rcvd_cnt % 250 < 40) ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_if.valid) @(posedge clk_i);
      rcvd_cnt++;
      got.read_value = rsp_if.read_value;
      got.status     = ilie_pkg::status_e'(rsp_if.status);
      got.count      = rsp_if.count;
      got.is_empty   = rsp_if.is_empty;
      if (pending_rsp.size() == 0) begin
        err_cnt++;
        if (err_cnt <= REPORT_MAX)
          $display("%0t: result with no request outstanding: rv=%h st=%0d cnt=%0d emp=%0b",
                   $realtime, got.read_value, got.status, got.count, got.is_empty);
      end else begin
        want = pending_rsp.pop_front();
        if (got.read_value !== want.read_value || got.status !== want.status ||
            got.count !== want.count || got.is_empty !== want.is_empty) begin
          err_cnt++;
          if (err_cnt <= REPORT_MAX) begin
            $display("%0t: result %0d mismatch: exp rv=%h st=%0d cnt=%0d emp=%0b",
                     $realtime, rcvd_cnt, want.read_value, want.status, want.count,
                     want.is_empty);
            $display("    got rv=%h st=%0d cnt=%0d emp=%0b",
                     got.read_value, got.status, got.count, got.is_empty);
          end
        end
      end
    end
  end

endmodule
